FILE: rtl/core/percent_escape_decoder_assert.svh
// ----------------------------------------------------------------------------
// percent_escape_decoder_assert.svh
// Assertion macros shared by the decoder's checker.
// ----------------------------------------------------------------------------
`ifndef PERCENT_ESCAPE_DECODER_ASSERT_SVH
`define PERCENT_ESCAPE_DECODER_ASSERT_SVH

// Clocked assertion, off while reset is asserted.
`define PED_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PED_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/core/ped_pkg.sv
// ----------------------------------------------------------------------------
// ped_pkg
// Types, constants and hex helpers for the percent escape decoder.
// ----------------------------------------------------------------------------
package ped_pkg;

  localparam logic [7:0] PctChar = 8'h25;
  localparam int unsigned GrpBytes = 3;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_t;

  // Bytes produced by one input transaction, oldest in data[0].
  typedef struct packed {
    logic [GrpBytes-1:0][7:0] data;
    logic [1:0]               cnt;   // 1..3
    logic                     last;  // group ends the string
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef enum logic [2:0] {
    PhIdle = 3'b001,
    PhPct  = 3'b010,
    PhHex  = 3'b100
  } phase_e;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
           (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c >= 8'h41 && c <= 8'h46) begin
      v = c - 8'h37;
    end else if (c >= 8'h61 && c <= 8'h66) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

FILE: rtl/core/ped_front.sv
// ----------------------------------------------------------------------------
// ped_front
// Escape state machine: classifies each byte and builds its output group.
// ----------------------------------------------------------------------------
module ped_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  ped_pkg::in_t  in_i,
  output logic          grp_valid_o,
  output ped_pkg::grp_t grp_o
);

  ped_pkg::phase_e phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic [7:0] b;
  logic [1:0] n;
  logic [ped_pkg::GrpBytes-1:0][7:0] data;

  assign b = in_i.in_byte;

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    n       = 2'd0;
    data    = '0;
    case (phase_q)
      ped_pkg::PhPct: begin
        phase_d = ped_pkg::PhIdle;
        if (ped_pkg::is_hex(b)) begin
          held_d  = b;
          phase_d = ped_pkg::PhHex;
        end else if (b == ped_pkg::PctChar) begin
          data[n] = ped_pkg::PctChar; n = n + 2'd1;
        end else begin
          data[n] = ped_pkg::PctChar; n = n + 2'd1;
          data[n] = b;                n = n + 2'd1;
        end
      end
      ped_pkg::PhHex: begin
        phase_d = ped_pkg::PhIdle;
        if (ped_pkg::is_hex(b)) begin
          data[n] = {ped_pkg::hex_val(held_q), ped_pkg::hex_val(b)}; n = n + 2'd1;
        end else begin
          // broken escape: literal '%' and digit, then b as in idle
          data[n] = ped_pkg::PctChar; n = n + 2'd1;
          data[n] = held_q;           n = n + 2'd1;
          if (b == ped_pkg::PctChar) begin
            phase_d = ped_pkg::PhPct;
          end else begin
            data[n] = b; n = n + 2'd1;
          end
        end
      end
      default: begin
        phase_d = ped_pkg::PhIdle;
        if (b == ped_pkg::PctChar) begin
          phase_d = ped_pkg::PhPct;
        end else begin
          data[n] = b; n = n + 2'd1;
        end
      end
    endcase

    // end of string: flush whatever escape is still open
    if (in_i.in_last) begin
      case (phase_d)
        ped_pkg::PhPct: begin
          data[n] = ped_pkg::PctChar; n = n + 2'd1;
        end
        ped_pkg::PhHex: begin
          data[n] = ped_pkg::PctChar; n = n + 2'd1;
          data[n] = held_d;           n = n + 2'd1;
        end
        default: ;
      endcase
      phase_d = ped_pkg::PhIdle;
    end
  end

  assign grp_valid_o = accept_i && (n != 2'd0);
  assign grp_o.data  = data;
  assign grp_o.cnt   = n;
  assign grp_o.last  = in_i.in_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ped_pkg::PhIdle;
      held_q  <= 8'h00;
    end else if (accept_i) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

endmodule

FILE: rtl/core/ped_fifo.sv
// ----------------------------------------------------------------------------
// ped_fifo
// Small register queue of byte groups between front and back.
// ----------------------------------------------------------------------------
module ped_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [Width-1:0]    wr_data_i,
  input  logic                rd_en_i,
  output logic [Width-1:0]    rd_data_o,
  output ped_pkg::fifo_stat_t stat_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_wr        = wr_en_i && !stat_o.full;
  assign do_rd        = rd_en_i && !stat_o.empty;
  assign rd_data_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/ped_back.sv
// ----------------------------------------------------------------------------
// ped_back
// Serializes byte groups into single result transactions via an output reg.
// ----------------------------------------------------------------------------
module ped_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  ped_pkg::grp_t head_i,
  output logic          head_pop_o,
  input  logic          pop,
  output logic          empty,
  output ped_pkg::out_t out_o
);

  logic [1:0]    idx_q, idx_d;
  logic          out_v_q, out_v_d;
  ped_pkg::out_t out_q, out_d;
  logic          slot_free, emit, grp_end;

  assign slot_free  = !out_v_q || pop;
  assign emit       = head_valid_i && slot_free;
  assign grp_end    = (idx_q == head_i.cnt - 2'd1);
  assign head_pop_o = emit && grp_end;

  always_comb begin
    idx_d              = idx_q;
    out_v_d            = out_v_q && !pop;
    out_d              = out_q;
    if (emit) begin
      out_v_d          = 1'b1;
      out_d.out_byte   = head_i.data[idx_q];
      out_d.run_last   = grp_end;
      out_d.string_end = grp_end && head_i.last;
      idx_d            = grp_end ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      out_v_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign empty = !out_v_q;
  assign out_o = out_q;

endmodule

FILE: rtl/core/percent_escape_decoder.sv
// ----------------------------------------------------------------------------
// percent_escape_decoder
// Streaming decoder for percent escapes, one raw byte per transaction.
// ----------------------------------------------------------------------------
// Input side is a queue write port: a transaction happens on a clock edge
// with push high and full low, carrying in_i.in_byte and in_i.in_last.
// Result side is a queue read port: while empty is low, out_o shows the
// oldest decoded byte; it is taken on an edge with pop high.
//
// Each input yields 0 to 3 result bytes. run_last flags the last byte of an
// input's group, string_end the final byte of a string (in_last input).
// A result passes through the group queue and then the output register on its
// way to out_o. Throughput: one input per cycle while full is low, limited
// by the back end emitting one result byte per cycle while pop keeps up;
// inputs that expand to 2 or 3 bytes hold the back end for each of their
// bytes, absorbed by the group queue of FifoDepth entries.
// Reset (async, active low) returns the escape state to idle and empties
// the group queue and output register; empty is high, full low.
// When the receiver stalls, the output register holds, then the queue
// fills and full rises; the escape state advances only on accepted input.
// ----------------------------------------------------------------------------
module percent_escape_decoder #(
  parameter int unsigned FifoDepth = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push,
  output logic          full,
  input  ped_pkg::in_t  in_i,
  output logic          empty,
  input  logic          pop,
  output ped_pkg::out_t out_o
);

  logic                accept;
  logic                grp_valid;
  ped_pkg::grp_t       grp_wr, grp_head;
  logic                head_pop;
  ped_pkg::fifo_stat_t fifo_stat;

  // Full tracks the group queue; a byte that yields nothing still waits.
  assign full   = fifo_stat.full;
  assign accept = push && !full;

  ped_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_i        (in_i),
    .grp_valid_o (grp_valid),
    .grp_o       (grp_wr)
  );

  ped_fifo #(
    .Width ($bits(ped_pkg::grp_t)),
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (grp_valid),
    .wr_data_i (grp_wr),
    .rd_en_i   (head_pop),
    .rd_data_o (grp_head),
    .stat_o    (fifo_stat)
  );

  ped_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!fifo_stat.empty),
    .head_i       (grp_head),
    .head_pop_o   (head_pop),
    .pop          (pop),
    .empty        (empty),
    .out_o        (out_o)
  );

endmodule

FILE: rtl/core/ped_checker.sv
// ----------------------------------------------------------------------------
// ped_checker
// Port-level assertions for the percent escape decoder, bound to the top.
// ----------------------------------------------------------------------------
`include "percent_escape_decoder_assert.svh"

module ped_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          push,
  input logic          full,
  input ped_pkg::in_t  in_i,
  input logic          empty,
  input logic          pop,
  input ped_pkg::out_t out_o
);

  `PED_ASSERT_ALWAYS(a_reset_idle, !rst_ni |-> (empty && !full), "reset state not idle")
  `PED_ASSERT(a_out_hold, (!empty && !pop) |=> (!empty && $stable(out_o)), "stalled result changed")
  `PED_ASSERT(a_end_is_run_last, !empty |-> (!out_o.string_end || out_o.run_last), "string_end without run_last")
  `PED_ASSERT(a_full_needs_push, $rose(full) |-> $past(push && !full), "full rose with no transaction")

endmodule

bind percent_escape_decoder ped_checker u_checker (.*);
